>>> src/nhs_pkg.sv
// Shared types, constants and codes of the node health and selection unit.
package nhs_pkg;

	localparam int MaxNodes = 16;
	localparam int IdxW = $clog2(MaxNodes);
	localparam int CntW = $clog2(MaxNodes + 1);

	localparam logic [15:0] WeightOne = 16'd256;
	localparam logic [15:0] WeightMin = 16'd26;
	localparam logic [10:0] LoadFull = 11'd1024;

	typedef enum logic [2:0] {
		ACT_ADD = 3'd0, ACT_REMOVE = 3'd1, ACT_SET_LOAD = 3'd2, ACT_SET_WEIGHT = 3'd3,
		ACT_HEARTBEAT = 3'd4, ACT_HEALTH = 3'd5, ACT_SELECT = 3'd6, ACT_NOP = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_DUP = 3'd1, ST_FULL = 3'd2, ST_NOTFOUND = 3'd3, ST_NONE = 3'd4
	} status_t;

	localparam logic [2:0] POL_RR = 3'd0;
	localparam logic [2:0] POL_LEAST = 3'd1;
	localparam logic [2:0] POL_WEIGHTED = 3'd2;
	localparam logic [2:0] POL_ADAPTIVE = 3'd3;
	localparam logic [2:0] POL_RANDOM = 3'd5;

	localparam logic [1:0] REG_POLICY = 2'd0;
	localparam logic [1:0] REG_INTERVAL = 2'd1;
	localparam logic [1:0] REG_MAXFAIL = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_LOOKUP, S_EXEC, S_SHIFT, S_HEALTH, S_SCAN1, S_SCAN2,
		S_MUL1, S_MUL2, S_MUL3, S_NEXT, S_RESULT
	} state_t;

	// Command group from the controller to the datapath.
	typedef struct packed {
		logic load_item;   // capture the input transaction
		logic clr_idx;     // index counter to zero
		logic inc_idx;     // index counter up by one
		logic look_step;   // compare one entry for the id lookup
		logic exec;        // apply add / set / heartbeat
		logic shift_step;  // move entry idx+1 down to idx
		logic shift_done;  // node count down by one
		logic health_step; // health update of entry idx
		logic scan_step;   // selection step on entry idx (pass 1 or 2)
		logic mul1;        // adaptive product stages
		logic mul2;
		logic mul3;
		logic rr_start;    // rotate index to rotor start
		logic finish;      // build the result
	} cmd_t;

	// Status group from the datapath to the controller.
	typedef struct packed {
		action_t  act;
		logic [2:0] policy;
		logic     idx_last;  // idx is the last entry below count, or the last round-robin step
		logic     empty;     // count is zero
		logic     found;     // lookup hit
		logic     shift_end; // idx+1 reaches count
		logic     hit_done;  // round robin or weighted pick found
	} stat_t;

endpackage

>>> src/nhs_ctrl.sv
// Controller state machine of the node health and selection unit.
module nhs_ctrl
	import nhs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_fire,
	input  logic  out_busy,
	input  stat_t st,
	output cmd_t  cmd,
	output logic  idle
);

	state_t state_q, nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= nxt;
	end

	always_comb begin
		nxt = state_q;
		cmd = '0;
		idle = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				if (in_fire) begin
					cmd.load_item = 1'b1;
					cmd.clr_idx = 1'b1;
					nxt = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				if (st.act == ACT_HEALTH) begin
					nxt = st.empty ? S_RESULT : S_HEALTH;
				end else if (st.act == ACT_SELECT) begin
					if (st.empty) nxt = S_RESULT;
					else begin
						if (st.policy == POL_RR) cmd.rr_start = 1'b1;
						nxt = (st.policy == POL_ADAPTIVE) ? S_MUL1 : S_SCAN1;
					end
				end else if (st.act == ACT_NOP) begin
					nxt = S_RESULT;
				end else if (st.empty || st.found) begin
					nxt = S_EXEC;
				end else begin
					cmd.look_step = 1'b1;
					if (st.idx_last) nxt = S_EXEC;
					else cmd.inc_idx = 1'b1;
				end
			end
			S_EXEC: begin
				if (st.act == ACT_REMOVE && st.found) begin
					nxt = S_SHIFT;
				end else begin
					cmd.exec = 1'b1;
					nxt = S_RESULT;
				end
			end
			S_SHIFT: begin
				if (st.shift_end) begin
					cmd.shift_done = 1'b1;
					nxt = S_RESULT;
				end else begin
					cmd.shift_step = 1'b1;
					cmd.inc_idx = 1'b1;
				end
			end
			S_HEALTH: begin
				cmd.health_step = 1'b1;
				cmd.inc_idx = 1'b1;
				if (st.idx_last) nxt = S_RESULT;
			end
			S_SCAN1: begin
				cmd.scan_step = 1'b1;
				if (st.hit_done) nxt = S_RESULT;
				else if (st.idx_last) begin
					cmd.clr_idx = 1'b1;
					if (st.policy == POL_WEIGHTED || st.policy == POL_RANDOM) nxt = S_SCAN2;
					else nxt = S_RESULT;
				end else cmd.inc_idx = 1'b1;
			end
			S_SCAN2: begin
				cmd.scan_step = 1'b1;
				if (st.hit_done || st.idx_last) nxt = S_RESULT;
				else cmd.inc_idx = 1'b1;
			end
			S_MUL1: begin cmd.mul1 = 1'b1; nxt = S_MUL2; end
			S_MUL2: begin cmd.mul2 = 1'b1; nxt = S_MUL3; end
			S_MUL3: begin cmd.mul3 = 1'b1; nxt = S_NEXT; end
			S_NEXT: begin
				if (st.idx_last) nxt = S_RESULT;
				else begin
					cmd.inc_idx = 1'b1;
					nxt = S_MUL1;
				end
			end
			S_RESULT: begin
				if (!out_busy) begin
					cmd.finish = 1'b1;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

endmodule

>>> src/nhs_datapath.sv
// Node table, lookup, health and selection datapath.
module nhs_datapath
	import nhs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [2:0]  scan_pass,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic [2:0]  in_action,
	input  logic [31:0] in_node_id,
	input  logic [10:0] in_load,
	input  logic [15:0] in_weight,
	input  logic [15:0] in_capacity,
	input  logic [47:0] in_now_ms,
	input  logic [15:0] in_random,
	output stat_t       st,
	output logic [2:0]  res_status,
	output logic [31:0] res_chosen,
	output logic        res_offline
);

	logic [2:0]  policy_q;
	logic [15:0] interval_q;
	logic [7:0]  maxfail_q;

	logic [31:0] ident_q [MaxNodes];
	logic [MaxNodes-1:0] online_q;
	logic [10:0] load_q [MaxNodes];
	logic [15:0] weight_q [MaxNodes];
	logic [15:0] cap_q [MaxNodes];
	logic [7:0]  fail_q [MaxNodes];
	logic [47:0] beat_q [MaxNodes];
	logic [CntW-1:0] count_q;
	logic [IdxW-1:0] rotor_q;

	action_t     act_q;
	logic [31:0] id_q;
	logic [10:0] ld_q;
	logic [15:0] wt_q, cp_q, rnd_q;
	logic [47:0] now_q;

	logic [IdxW-1:0] idx_q, hit_q, best_q;
	logic        found_q, best_v_q, off_q, done_q;
	logic [10:0] low_load_q;
	logic [19:0] total_q, cum_q;
	logic [45:0] top_score_q;
	logic [14:0] p1_s1;
	logic [29:0] p1_s2;
	logic [45:0] p1_s3;
	logic [CntW-1:0] ticks_q;
	logic        adapt_eval, full_flag_q;

	logic [CntW-1:0] idx_ext, idx_p1;
	logic [IdxW-1:0] cur;
	logic [47:0] elapsed;
	logic [17:0] timeout;
	logic [7:0]  fail_inc;
	logic [3:0]  avail;
	logic [35:0] lhs;
	logic [35:0] rhs;
	logic [19:0] cum_n;
	logic [7:0]  rr_r0, rr_r1, rr_r2, rr_r3, rr_r4;
	logic        look_hit;

	assign idx_ext = CntW'(idx_q);
	assign idx_p1 = idx_ext + 1'b1;
	assign cur = idx_q;

	assign st.act = act_q;
	assign st.policy = policy_q;
	// A round-robin sweep starts at the rotor and wraps, so its end is set by the step count.
	assign st.idx_last = (act_q == ACT_SELECT && policy_q == POL_RR) ?
		(ticks_q + 1'b1 >= count_q) : (idx_p1 >= count_q);
	assign st.empty = (count_q == '0);
	assign st.found = found_q;
	assign st.shift_end = (idx_p1 >= count_q);
	assign st.hit_done = done_q;

	assign look_hit = cmd.look_step && (ident_q[cur] == id_q);

	assign elapsed = now_q - beat_q[cur];
	assign timeout = {2'b00, interval_q} + {1'b0, interval_q, 1'b0};
	assign fail_inc = (fail_q[cur] == 8'hFF) ? 8'hFF : fail_q[cur] + 8'd1;
	assign avail = (fail_q[cur] >= 8'd5) ? 4'd1 : 4'd10 - {fail_q[cur][2:0], 1'b0};
	assign cum_n = cum_q + 20'(weight_q[cur]);
	assign lhs = 36'(rnd_q) * 36'(total_q);
	assign rhs = {cum_n, 16'h0000};

	// Round-robin start: rotor mod count by shift and subtract. The rotor can
	// exceed the count after removals, so a single subtraction is not enough.
	assign rr_r0 = 8'(rotor_q);
	assign rr_r1 = (rr_r0 >= {count_q, 3'b000}) ? rr_r0 - {count_q, 3'b000} : rr_r0;
	assign rr_r2 = (rr_r1 >= 8'({count_q, 2'b00})) ? rr_r1 - 8'({count_q, 2'b00}) : rr_r1;
	assign rr_r3 = (rr_r2 >= 8'({count_q, 1'b0})) ? rr_r2 - 8'({count_q, 1'b0}) : rr_r2;
	assign rr_r4 = (rr_r3 >= 8'(count_q)) ? rr_r3 - 8'(count_q) : rr_r3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_RR;
			interval_q <= 16'd1000;
			maxfail_q <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_POLICY: policy_q <= cfg_data[2:0];
				REG_INTERVAL: interval_q <= cfg_data;
				REG_MAXFAIL: maxfail_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Control state of the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			online_q <= '0;
			count_q <= '0;
			rotor_q <= '0;
			act_q <= ACT_NOP;
		end else begin
			if (cmd.load_item) act_q <= action_t'(in_action);
			if (cmd.exec && act_q == ACT_ADD && !found_q && count_q < CntW'(MaxNodes)) begin
				online_q[count_q[IdxW-1:0]] <= 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (cmd.shift_step) online_q[cur] <= online_q[cur + 1'b1];
			if (cmd.shift_done) count_q <= count_q - 1'b1;
			if (cmd.health_step && online_q[cur] && elapsed > 48'(timeout)
				&& fail_inc >= maxfail_q) online_q[cur] <= 1'b0;
			if (cmd.scan_step && policy_q == POL_RR && !done_q && online_q[cur])
				rotor_q <= (idx_p1 >= count_q) ? '0 : idx_p1[IdxW-1:0];
		end
	end

	// Table payload.
	always_ff @(posedge clk) begin
		if (cmd.exec && act_q == ACT_ADD && !found_q && count_q < CntW'(MaxNodes)) begin
			ident_q[count_q[IdxW-1:0]] <= id_q;
			load_q[count_q[IdxW-1:0]] <= '0;
			weight_q[count_q[IdxW-1:0]] <= WeightOne;
			cap_q[count_q[IdxW-1:0]] <= cp_q;
			fail_q[count_q[IdxW-1:0]] <= '0;
			beat_q[count_q[IdxW-1:0]] <= now_q;
		end
		if (cmd.exec && found_q) begin
			case (act_q)
				ACT_SET_LOAD: load_q[hit_q] <= (ld_q > LoadFull) ? LoadFull : ld_q;
				ACT_SET_WEIGHT: weight_q[hit_q] <= (wt_q == '0) ? WeightMin : wt_q;
				ACT_HEARTBEAT: begin
					beat_q[hit_q] <= now_q;
					if (fail_q[hit_q] != '0) fail_q[hit_q] <= fail_q[hit_q] - 8'd1;
				end
				default: ;
			endcase
		end
		if (cmd.shift_step) begin
			ident_q[cur] <= ident_q[cur + 1'b1];
			load_q[cur] <= load_q[cur + 1'b1];
			weight_q[cur] <= weight_q[cur + 1'b1];
			cap_q[cur] <= cap_q[cur + 1'b1];
			fail_q[cur] <= fail_q[cur + 1'b1];
			beat_q[cur] <= beat_q[cur + 1'b1];
		end
		if (cmd.health_step && online_q[cur]) begin
			if (elapsed > 48'(timeout)) fail_q[cur] <= fail_inc;
			else if (fail_q[cur] != '0) fail_q[cur] <= fail_q[cur] - 8'd1;
		end
	end

	// Item capture, scan state and the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			found_q <= 1'b0;
			done_q <= 1'b0;
			off_q <= 1'b0;
			best_v_q <= 1'b0;
			res_status <= ST_OK;
			res_chosen <= '0;
			res_offline <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				id_q <= in_node_id;
				ld_q <= in_load;
				wt_q <= in_weight;
				cp_q <= in_capacity;
				now_q <= in_now_ms;
				rnd_q <= in_random;
				found_q <= 1'b0;
				done_q <= 1'b0;
				off_q <= 1'b0;
				best_v_q <= 1'b0;
				low_load_q <= LoadFull;
				top_score_q <= '0;
				total_q <= '0;
				cum_q <= '0;
				ticks_q <= '0;
			end
			// A lookup hit holds the index on the matching entry for the shift.
			if (cmd.clr_idx) idx_q <= '0;
			else if (cmd.rr_start) idx_q <= rr_r4[IdxW-1:0];
			else if (cmd.inc_idx && !look_hit) begin
				if (cmd.scan_step && policy_q == POL_RR)
					idx_q <= (idx_p1 >= count_q) ? '0 : idx_p1[IdxW-1:0];
				else idx_q <= idx_p1[IdxW-1:0];
			end
			if (look_hit) begin
				found_q <= 1'b1;
				hit_q <= cur;
			end
			if (cmd.health_step && online_q[cur] && elapsed > 48'(timeout)
				&& fail_inc >= maxfail_q) off_q <= 1'b1;
			if (cmd.scan_step && !done_q) begin
				if (policy_q == POL_RR) begin
					ticks_q <= ticks_q + 1'b1;
					if (online_q[cur]) begin
						done_q <= 1'b1;
						best_v_q <= 1'b1;
						best_q <= cur;
					end
				end else if (policy_q == POL_WEIGHTED || policy_q == POL_RANDOM) begin
					if (scan_pass == 3'd1) begin
						if (online_q[cur]) total_q <= total_q + 20'(weight_q[cur]);
					end else if (online_q[cur]) begin
						cum_q <= cum_n;
						if (total_q != '0 && lhs <= rhs) begin
							done_q <= 1'b1;
							best_v_q <= 1'b1;
							best_q <= cur;
						end
					end
				end else begin
					if (online_q[cur] && load_q[cur] < low_load_q) begin
						low_load_q <= load_q[cur];
						best_v_q <= 1'b1;
						best_q <= cur;
					end
				end
			end
			if (cmd.mul1) p1_s1 <= 15'(avail) * 15'(LoadFull - load_q[cur]);
			if (cmd.mul2) p1_s2 <= 30'(p1_s1) * 30'(cap_q[cur]);
			if (cmd.mul3) p1_s3 <= 46'(p1_s2) * 46'(weight_q[cur]);
			if (cmd.finish) begin
				res_offline <= (act_q == ACT_HEALTH) ? off_q : 1'b0;
				res_chosen <= (act_q == ACT_SELECT && best_v_q) ? ident_q[best_q] : '0;
				case (act_q) inside
					ACT_ADD: res_status <= found_q ? ST_DUP : (full_flag_q ? ST_FULL : ST_OK);
					ACT_REMOVE, ACT_SET_LOAD, ACT_SET_WEIGHT, ACT_HEARTBEAT:
						res_status <= found_q ? ST_OK : ST_NOTFOUND;
					ACT_SELECT: res_status <= best_v_q ? ST_OK : ST_NONE;
					default: res_status <= ST_OK;
				endcase
			end
			if (adapt_eval) begin
				if (!best_v_q || p1_s3 > top_score_q) begin
					best_v_q <= 1'b1;
					top_score_q <= p1_s3;
					best_q <= cur;
				end
			end
		end
	end

	// Adaptive compare runs in the cycle after the last product stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adapt_eval <= 1'b0;
			full_flag_q <= 1'b0;
		end else begin
			adapt_eval <= cmd.mul3 && online_q[cur];
			if (cmd.exec) full_flag_q <= (count_q >= CntW'(MaxNodes));
		end
	end

endmodule

>>> src/node_health_and_selection_unit.sv
// Top level of the node health and selection unit.
// The unit keeps a compacted table of up to sixteen worker nodes and applies one
// action per input transaction: add, remove, set load, set weight, heartbeat,
// health check, select or no-op. Every transaction produces exactly one result
// transaction carrying status, chosen node id and the went-offline flag. The
// unit works on one transaction at a time; its time is set by a single table
// index that walks the entries one per cycle, apart from adaptive selection.
// Add and the set and heartbeat actions go through id lookup, execute, result
// and idle; remove adds the shift of the upper entries; a health check and
// least-loaded or round-robin selection make one sweep; weighted selection
// makes two passes; adaptive selection takes each node through a three-stage
// product chain. The result state holds while the previous result still waits
// for the consumer. The result register parts the two sides: the next
// transaction is taken as soon as the result is loaded, even while it still
// waits for the consumer.
// Configuration writes are taken at any time but are meant for idle periods;
// the policy register selects round robin, least loaded, weighted random or
// adaptive selection, with affinity and unused codes falling back to least loaded.
module node_health_and_selection_unit
	import nhs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// action[2:0], node_id[34:3], load[45:35], weight[61:46], capacity[77:62],
	// now_ms[125:78], random_value[141:126], zero fill up to bit 143
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[2:0], chosen_node[34:3], went_offline[35], zero fill up to bit 39
	output logic [39:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	cmd_t  cmd;
	stat_t st;
	logic  idle, in_fire, out_busy;
	logic  valid_q;
	logic [2:0] pass_q;
	logic [2:0]  r_status;
	logic [31:0] r_chosen;
	logic        r_off;

	assign s_tready = idle;
	assign in_fire = s_tvalid && s_tready;
	// The result register may be reloaded only once the previous result left.
	assign out_busy = valid_q && !m_tready;

	// Pass number of a selection scan: one for the first sweep, two for the second.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pass_q <= 3'd1;
		else if (cmd.load_item) pass_q <= 3'd1;
		else if (cmd.scan_step && cmd.clr_idx) pass_q <= 3'd2;
	end

	nhs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_busy(out_busy),
		.st(st), .cmd(cmd), .idle(idle)
	);

	nhs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .scan_pass(pass_q),
		.cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.in_action(s_tdata[2:0]), .in_node_id(s_tdata[34:3]),
		.in_load(s_tdata[45:35]), .in_weight(s_tdata[61:46]),
		.in_capacity(s_tdata[77:62]), .in_now_ms(s_tdata[125:78]),
		.in_random(s_tdata[141:126]), .st(st),
		.res_status(r_status), .res_chosen(r_chosen), .res_offline(r_off)
	);

	// The datapath result registers serve as the output register; valid follows finish.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (cmd.finish) valid_q <= 1'b1;
		else if (m_tready) valid_q <= 1'b0;
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {4'b0000, r_off, r_chosen, r_status};

endmodule

>>> dv/nhs_checker.sv
// Checker for the node health and selection unit: table model, prediction and comparison.
`timescale 1ns / 100ps
module nhs_checker
	import nhs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [143:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [39:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	output int           fail_count,
	output int           pending
);

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] chosen;
		logic        offline;
	} outcome_t;

	logic [2:0]  pol;
	logic [15:0] interval;
	logic [7:0]  maxfail;

	logic [31:0] t_id   [MaxNodes];
	logic        t_on   [MaxNodes];
	logic [10:0] t_load [MaxNodes];
	logic [15:0] t_wt   [MaxNodes];
	logic [15:0] t_cap  [MaxNodes];
	logic [7:0]  t_fail [MaxNodes];
	logic [47:0] t_beat [MaxNodes];
	int          count;
	int          rot;

	outcome_t outcome_q[$];

	assign pending = outcome_q.size();

	function automatic int find_node(logic [31:0] id);
		for (int i = 0; i < count; i++)
			if (t_id[i] == id) return i;
		return -1;
	endfunction

	task automatic report(string what, logic [39:0] got, logic [39:0] want);
		$display("MISMATCH %s at %0t: got %h want %h", what, $realtime, got, want);
		fail_count++;
	endtask

	function automatic outcome_t apply_action(logic [143:0] d);
		action_t     act;
		logic [31:0] id;
		logic [10:0] ld;
		logic [15:0] wt, cap, rnd;
		logic [47:0] now, el;
		outcome_t    r;
		int          k;
		logic [63:0] total, cum, score, top_score, av;
		logic [10:0] low_load;
		act = action_t'(d[2:0]);
		id = d[34:3];
		ld = d[45:35];
		wt = d[61:46];
		cap = d[77:62];
		now = d[125:78];
		rnd = d[141:126];
		r = '0;
		r.status = ST_OK;
		k = -1;
		case (act)
			ACT_ADD: begin
				if (find_node(id) >= 0) r.status = ST_DUP;
				else if (count >= MaxNodes) r.status = ST_FULL;
				else begin
					t_id[count] = id; t_on[count] = 1; t_load[count] = 0;
					t_wt[count] = WeightOne; t_cap[count] = cap; t_fail[count] = 0;
					t_beat[count] = now; count++;
				end
			end
			ACT_REMOVE: begin
				k = find_node(id);
				if (k < 0) r.status = ST_NOTFOUND;
				else begin
					for (int i = k; i + 1 < count; i++) begin
						t_id[i] = t_id[i+1]; t_on[i] = t_on[i+1]; t_load[i] = t_load[i+1];
						t_wt[i] = t_wt[i+1]; t_cap[i] = t_cap[i+1]; t_fail[i] = t_fail[i+1];
						t_beat[i] = t_beat[i+1];
					end
					count--;
				end
			end
			ACT_SET_LOAD, ACT_SET_WEIGHT, ACT_HEARTBEAT: begin
				k = find_node(id);
				if (k < 0) r.status = ST_NOTFOUND;
				else if (act == ACT_SET_LOAD) t_load[k] = (ld > LoadFull) ? LoadFull : ld;
				else if (act == ACT_SET_WEIGHT) t_wt[k] = (wt != 0) ? wt : WeightMin;
				else begin
					t_beat[k] = now;
					if (t_fail[k] != 0) t_fail[k]--;
				end
			end
			ACT_HEALTH: begin
				for (int i = 0; i < count; i++) begin
					if (!t_on[i]) continue;
					el = now - t_beat[i];
					if ({16'd0, el} > 64'(interval) * 3) begin
						if (t_fail[i] != 8'hFF) t_fail[i]++;
						if (t_fail[i] >= maxfail) begin
							t_on[i] = 0;
							r.offline = 1;
						end
					end else if (t_fail[i] != 0) t_fail[i]--;
				end
			end
			ACT_SELECT: begin
				if (pol == POL_RR) begin
					if (count > 0)
						for (int i = 0; i < count; i++) begin
							int j;
							j = ((rot % count) + i) % count;
							if (t_on[j]) begin
								k = j;
								rot = (j + 1) % count;
								break;
							end
						end
				end else if (pol == POL_WEIGHTED || pol == POL_RANDOM) begin
					total = 0; cum = 0;
					for (int i = 0; i < count; i++) if (t_on[i]) total += t_wt[i];
					if (total != 0)
						for (int i = 0; i < count; i++)
							if (t_on[i]) begin
								cum += t_wt[i];
								if (64'(rnd) * total <= (cum << 16)) begin
									k = i;
									break;
								end
							end
				end else if (pol == POL_ADAPTIVE) begin
					top_score = 0;
					for (int i = 0; i < count; i++) begin
						if (!t_on[i]) continue;
						av = (t_fail[i] >= 5) ? 1 : 10 - 2 * t_fail[i];
						score = av * (64'(LoadFull) - t_load[i]) * t_cap[i] * t_wt[i];
						if (k < 0 || score > top_score) begin
							k = i;
							top_score = score;
						end
					end
				end else begin
					low_load = LoadFull;
					for (int i = 0; i < count; i++)
						if (t_on[i] && t_load[i] < low_load) begin
							k = i;
							low_load = t_load[i];
						end
				end
				if (k < 0) r.status = ST_NONE;
				else r.chosen = t_id[k];
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t w;
		if (!arst_n) begin
			pol <= POL_RR;
			interval <= 16'd1000;
			maxfail <= 8'd3;
			count = 0;
			rot = 0;
			fail_count = 0;
			for (int i = 0; i < MaxNodes; i++) t_on[i] = 0;
			outcome_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (outcome_q.size() == 0) report("unexpected result", m_tdata, '0);
				else begin
					w = outcome_q.pop_front();
					if (m_tdata[2:0] != w.status) report("status", m_tdata, 40'(w));
					if (m_tdata[34:3] != w.chosen) report("chosen_node", m_tdata, 40'(w));
					if (m_tdata[35] != w.offline) report("went_offline", m_tdata, 40'(w));
				end
			end
			if (s_tvalid && s_tready) outcome_q.push_back(apply_action(s_tdata));
			if (cfg_we) begin
				if (cfg_index == REG_POLICY) pol <= cfg_data[2:0];
				else if (cfg_index == REG_INTERVAL) interval <= cfg_data;
				else if (cfg_index == REG_MAXFAIL) maxfail <= cfg_data[7:0];
			end
		end
	end

endmodule

>>> dv/tb_node_health_and_selection_unit.sv
// Testbench top: stimulus, configuration phases and verdict for the node selection unit.
`timescale 1ns / 100ps
module tb_node_health_and_selection_unit;
	import nhs_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [39:0]  m_tdata;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [15:0]  cfg_data;
	int           fail_count;
	int           pending;

	// Percent chance per cycle that the sender or the receiver holds off.
	int send_idle;
	int recv_idle;
	int stall_cycles;
	// Base time; heartbeat and health check times are drawn near it.
	logic [47:0] clock_ms;
	logic [31:0] id_pool[8];

	localparam int WatchdogLimit = 20000;

	node_health_and_selection_unit dut (.*);

	nhs_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// The receiver stalls at random; it changes only at the falling edge.
	always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

	// The watchdog counts cycles in which neither side moves a transaction.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			stall_cycles <= 0;
		else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WatchdogLimit) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Pack one input item into the stream layout.
	function automatic logic [143:0] pack_item(action_t act, logic [31:0] id, logic [10:0] ld,
			logic [15:0] wt, logic [15:0] cap, logic [47:0] now, logic [15:0] rnd);
		return {2'b00, rnd, now, cap, wt, ld, id, act};
	endfunction

	// Offer one transaction, idling first at random, and hold it until taken.
	// Valid stays high past the accepting edge until the next falling edge
	// decides what comes next; the unit is busy in that half cycle.
	task automatic send_item(logic [143:0] d);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Writes happen only once every result is back and the unit is settled.
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		s_tvalid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// Random item that mostly addresses ids known to the pool so lookups hit.
	task automatic random_item();
		action_t     act;
		logic [31:0] id;
		logic [47:0] now;
		int          r;
		r = $urandom_range(99);
		if (r < 14) act = ACT_ADD;
		else if (r < 22) act = ACT_REMOVE;
		else if (r < 34) act = ACT_SET_LOAD;
		else if (r < 44) act = ACT_SET_WEIGHT;
		else if (r < 58) act = ACT_HEARTBEAT;
		else if (r < 70) act = ACT_HEALTH;
		else if (r < 98) act = ACT_SELECT;
		else act = ACT_NOP;
		id = ($urandom_range(9) == 0) ? $urandom() : id_pool[$urandom_range(7)];
		clock_ms = clock_ms + $urandom_range(3000);
		now = ($urandom_range(19) == 0) ? 48'({$urandom(), $urandom()}) : clock_ms;
		send_item(pack_item(act, id,
			($urandom_range(3) == 0) ? 11'($urandom()) : 11'($urandom_range(1024)),
			($urandom_range(7) == 0) ? 16'd0 : 16'($urandom()),
			16'($urandom()), now, 16'($urandom())));
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		m_tready = 0;
		cfg_we = 0;
		cfg_index = REG_POLICY;
		cfg_data = '0;
		stall_cycles = 0;
		send_idle = 15;
		recv_idle = 53;
		clock_ms = 48'd5000;
		for (int i = 0; i < 8; i++) id_pool[i] = $urandom();
		id_pool[0] = 32'd0;
		id_pool[1] = 32'hFFFF_FFFF;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part: empty table, extreme fields, duplicates, a full table,
		// saturated load, zero weight and a time that wraps around.
		send_item(pack_item(ACT_SELECT, 0, 0, 0, 0, 0, 0));
		send_item(pack_item(ACT_REMOVE, 32'h1234, 0, 0, 0, 0, 0));
		send_item(pack_item(ACT_HEALTH, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 0));
		for (int i = 0; i < 17; i++)
			send_item(pack_item(ACT_ADD, (i < 2) ? id_pool[i] : 32'h100 + i, 0, 0,
				(i == 0) ? 16'hFFFF : 16'(i * 97), 48'hFFFF_FFFF_FF00, 0));
		send_item(pack_item(ACT_ADD, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
		send_item(pack_item(ACT_SET_LOAD, 32'h0, 11'h7FF, 0, 0, 0, 0));
		send_item(pack_item(ACT_SET_WEIGHT, 32'h0, 0, 16'd0, 0, 0, 0));
		send_item(pack_item(ACT_SET_WEIGHT, 32'hFFFF_FFFF, 0, 16'hFFFF, 0, 0, 0));
		send_item(pack_item(ACT_HEARTBEAT, 32'h102, 0, 0, 0, 48'd10, 16'hFFFF));
		send_item(pack_item(ACT_HEALTH, 0, 0, 0, 0, 48'd20, 0));
		send_item(pack_item(ACT_NOP, 0, 0, 0, 0, 0, 0));
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_POLICY, 16'(p));
			send_item(pack_item(ACT_SELECT, 0, 0, 0, 0, 0, 16'hFFFF));
		end
		// Remove the nodes added beyond the two pool ids, so the other pool ids fit in the random part.
		for (int i = 2; i < 16; i++) send_item(pack_item(ACT_REMOVE, 32'h100 + i, 0, 0, 0, 0, 0));

		// Random phases: each setting of policy, interval and failure limit.
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 4) begin send_idle = 53; recv_idle = 15; end
			if (ph == 7) begin send_idle = 0; recv_idle = 0; end
			write_reg(REG_POLICY, 16'($urandom_range(7)));
			write_reg(REG_INTERVAL, (ph == 0) ? 16'd1 : (ph == 1) ? 16'hFFFF
				: 16'($urandom_range(1, 1500)));
			write_reg(REG_MAXFAIL, (ph == 2) ? 16'd1 : (ph == 3) ? 16'd255
				: 16'($urandom_range(1, 6)));
			for (int n = 0; n < 68; n++) random_item();
		end

		s_tvalid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule

>>> files.f
src/nhs_pkg.sv
src/nhs_ctrl.sv
src/nhs_datapath.sv
src/node_health_and_selection_unit.sv
dv/nhs_checker.sv
dv/tb_node_health_and_selection_unit.sv
